@@ src/sdinit_pkg.sv @@
// ----------------------------------------------------------------------------
// sdinit_pkg: shared types and constants for the SD SPI init sequencer
// Phase codes, request opcodes, register indexes and command framing.
// ----------------------------------------------------------------------------
`default_nettype none

package sdinit_pkg;

  localparam int unsigned POLL_W  = 8;
  localparam int unsigned RETRY_W = 10;
  localparam int unsigned DUMMY_W = 8;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned POS_W   = 8;

  localparam logic [POLL_W-1:0]  POLL_LIMIT_RST  = 8'd10;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 10'd100;
  localparam logic [DUMMY_W-1:0] DUMMY_COUNT_RST = 8'd10;

  localparam logic [7:0] BYTE_IDLE = 8'hFF;
  localparam logic [7:0] RESP_IDLE = 8'h01;
  localparam logic [7:0] RESP_OK   = 8'h00;
  localparam logic [7:0] CMD_START = 8'h40;
  localparam logic [7:0] CRC_CMD0  = 8'h95;
  localparam logic [7:0] CRC_CMD8  = 8'h87;
  localparam logic [7:0] CRC_NONE  = 8'hFF;
  localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;
  localparam logic [31:0] ARG_CMD16  = 32'd512;

  localparam logic [POS_W-1:0] POS_CRC  = 8'd5;
  localparam logic [POS_W-1:0] POS_POLL = 8'd6;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_XFER  = 2'd1,
    OP_DELAY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_POLL_LIMIT  = 2'd0,
    CFG_RETRY_LIMIT = 2'd1,
    CFG_DUMMY_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OC_RUN   = 2'd0,
    OC_READY = 2'd1,
    OC_FAIL  = 2'd2
  } outcome_t;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_DUMMY  = 10'b00_0000_0010,
    PH_CMD0   = 10'b00_0000_0100,
    PH_CMD8   = 10'b00_0000_1000,
    PH_CMD55  = 10'b00_0001_0000,
    PH_ACMD41 = 10'b00_0010_0000,
    PH_CMD16  = 10'b00_0100_0000,
    PH_WAIT   = 10'b00_1000_0000,
    PH_DONE   = 10'b01_0000_0000,
    PH_FAIL   = 10'b10_0000_0000
  } phase_t;

  // packed lowest field last: tx_byte lands in bits [7:0]
  typedef struct packed {
    logic [1:0] outcome;
    logic       fast_clock;
    logic       delay_request;
    logic       deselect_first;
    logic       select_level;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } res_t;

  function automatic logic [7:0] frame_byte(input phase_t ph, input logic [2:0] pos);
    logic [7:0]  idx;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    crc = CRC_NONE;
    unique case (ph)
      PH_CMD0: begin
        idx = 8'd0;  arg = 32'd0;      crc = CRC_CMD0;
      end
      PH_CMD8: begin
        idx = 8'd8;  arg = ARG_CMD8;   crc = CRC_CMD8;
      end
      PH_CMD55: begin
        idx = 8'd55; arg = 32'd0;
      end
      PH_ACMD41: begin
        idx = 8'd41; arg = ARG_ACMD41;
      end
      default: begin
        idx = 8'd16; arg = ARG_CMD16;
      end
    endcase
    unique case (pos)
      3'd0:    b = idx | CMD_START;
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ src/sd_spi_card_init_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// sd_spi_card_init_sequencer_core: SD card SPI-mode start-up sequencer
// Decides one SPI byte exchange per request: dummy bytes, command framing,
// response polling, ACMD41 retry loop, then grants the fast clock.
// ----------------------------------------------------------------------------
// Output: an accepted request's result is registered in the output register.
// Throughput: one request per cycle while the downstream side is ready; the output
//   register is refilled while the downstream side takes the held result.
// Reset: synchronous active-low; phase idle, counters cleared, registers at
//   defaults (poll 10, retries 100, dummy bytes 10), no result pending.
`default_nettype none

module sd_spi_card_init_sequencer_core
  import sdinit_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]        in_tuser,   // [1:0] op
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [7:0] tx_byte, [8] tx_valid, [9] select_level, [10] deselect_first,
  // [11] delay_request, [12] fast_clock, [14:13] outcome, [15] zero
  output logic [15:0]            out_tdata,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  logic [POLL_W-1:0]  poll_limit_r;
  logic [RETRY_W-1:0] retry_limit_r;
  logic [DUMMY_W-1:0] dummy_count_r;

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POLL_W-1:0]  poll_r, poll_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic               out_valid_r;
  res_t               res_r, res_nxt;

  logic               acc;
  logic [1:0]         op;
  logic [7:0]         rx;
  logic               fin;
  logic               got;
  logic [POLL_W-1:0]  poll_inc;
  logic [RETRY_W-1:0] retry_inc;
  logic [POS_W:0]     dummy_next;

  assign in_tready  = !out_valid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign op         = in_tuser;
  assign rx         = in_tdata;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  assign poll_inc   = (poll_r == '1) ? poll_r : poll_r + POLL_W'(1);
  assign retry_inc  = (retry_r == '1) ? retry_r : retry_r + RETRY_W'(1);
  assign dummy_next = {1'b0, pos_r} + (POS_W+1)'(1);

  function automatic res_t status_res(input phase_t ph, input logic desel);
    res_t r;
    r.tx_byte        = 8'd0;
    r.tx_valid       = 1'b0;
    r.select_level   = 1'b1;
    r.deselect_first = desel;
    r.delay_request  = 1'b0;
    r.fast_clock     = (ph == PH_DONE);
    r.outcome        = (ph == PH_DONE) ? OC_READY : ((ph == PH_FAIL) ? OC_FAIL : OC_RUN);
    return r;
  endfunction

  function automatic res_t byte_res(input logic [7:0] b, input logic sel,
                                    input logic desel);
    res_t r;
    r.tx_byte        = b;
    r.tx_valid       = 1'b1;
    r.select_level   = sel;
    r.deselect_first = desel;
    r.delay_request  = 1'b0;
    r.fast_clock     = 1'b0;
    r.outcome        = OC_RUN;
    return r;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    poll_nxt  = poll_r;
    retry_nxt = retry_r;
    res_nxt   = status_res(phase_r, 1'b0);
    fin       = 1'b0;
    got       = 1'b0;

    if (op == OP_START) begin
      phase_nxt = PH_DUMMY;
      pos_nxt   = '0;
      poll_nxt  = '0;
      retry_nxt = '0;
      res_nxt   = byte_res(BYTE_IDLE, 1'b1, 1'b0);
    end else if (op == OP_DELAY && phase_r == PH_WAIT) begin
      phase_nxt = PH_CMD55;
      pos_nxt   = '0;
      poll_nxt  = '0;
      res_nxt   = byte_res(frame_byte(PH_CMD55, 3'd0), 1'b0, 1'b0);
    end else if (op == OP_XFER) begin
      unique case (phase_r)
        PH_DUMMY: begin
          if (dummy_next >= {1'b0, dummy_count_r}) begin
            phase_nxt = PH_CMD0;
            pos_nxt   = '0;
            poll_nxt  = '0;
            res_nxt   = byte_res(frame_byte(PH_CMD0, 3'd0), 1'b0, 1'b0);
          end else begin
            pos_nxt = dummy_next[POS_W-1:0];
            res_nxt = byte_res(BYTE_IDLE, 1'b1, 1'b0);
          end
        end
        PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD16: begin
          if (pos_r < POS_CRC) begin
            pos_nxt = pos_r + POS_W'(1);
            res_nxt = byte_res(frame_byte(phase_r, pos_nxt[2:0]), 1'b0, 1'b0);
          end else if (pos_r == POS_CRC) begin
            pos_nxt  = POS_POLL;
            poll_nxt = '0;
            res_nxt  = byte_res(BYTE_IDLE, 1'b0, 1'b0);
          end else if (rx != BYTE_IDLE) begin
            fin = 1'b1;
            got = 1'b1;
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc >= poll_limit_r) begin
              fin = 1'b1;
            end else begin
              res_nxt = byte_res(BYTE_IDLE, 1'b0, 1'b0);
            end
          end
        end
        default: ;
      endcase
    end

    if (fin) begin
      unique case (phase_r)
        PH_CMD0: begin
          if (got && rx == RESP_IDLE) begin
            phase_nxt = PH_CMD8;
            pos_nxt   = '0;
            poll_nxt  = '0;
            res_nxt   = byte_res(frame_byte(PH_CMD8, 3'd0), 1'b0, 1'b1);
          end else begin
            phase_nxt = PH_FAIL;
            res_nxt   = status_res(PH_FAIL, 1'b1);
          end
        end
        PH_CMD8: begin
          if (got) begin
            phase_nxt = PH_CMD55;
            pos_nxt   = '0;
            poll_nxt  = '0;
            res_nxt   = byte_res(frame_byte(PH_CMD55, 3'd0), 1'b0, 1'b1);
          end else begin
            phase_nxt = PH_FAIL;
            res_nxt   = status_res(PH_FAIL, 1'b1);
          end
        end
        PH_CMD55: begin
          phase_nxt = PH_ACMD41;
          pos_nxt   = '0;
          poll_nxt  = '0;
          res_nxt   = byte_res(frame_byte(PH_ACMD41, 3'd0), 1'b0, 1'b1);
        end
        PH_ACMD41: begin
          if (got && rx == RESP_OK) begin
            phase_nxt = PH_CMD16;
            pos_nxt   = '0;
            poll_nxt  = '0;
            res_nxt   = byte_res(frame_byte(PH_CMD16, 3'd0), 1'b0, 1'b1);
          end else begin
            retry_nxt = retry_inc;
            if (retry_inc >= retry_limit_r) begin
              phase_nxt = PH_FAIL;
              res_nxt   = status_res(PH_FAIL, 1'b1);
            end else begin
              phase_nxt             = PH_WAIT;
              res_nxt               = status_res(PH_WAIT, 1'b1);
              res_nxt.delay_request = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_DONE;
          res_nxt   = status_res(PH_DONE, 1'b1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r  <= POLL_LIMIT_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
      dummy_count_r <= DUMMY_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POLL_LIMIT:  poll_limit_r  <= cfg_wdata[POLL_W-1:0];
        CFG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[RETRY_W-1:0];
        CFG_DUMMY_COUNT: dummy_count_r <= cfg_wdata[DUMMY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      poll_r      <= '0;
      retry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        poll_r  <= poll_nxt;
        retry_r <= retry_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

  a_delay_waits: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res_nxt.delay_request |=> phase_r == PH_WAIT)
    else $error("delay request without entering wait");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op == OP_START |=> phase_r == PH_DUMMY && retry_r == '0 && pos_r == '0)
    else $error("start did not restart the sequence");

  a_no_byte_deselect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.tx_valid |-> res_r.select_level && res_r.tx_byte == 8'd0)
    else $error("idle result with chip select low or stray byte");

  a_fast_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.fast_clock |-> res_r.outcome == OC_READY)
    else $error("fast clock before card ready");

  a_cmd_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CMD0 || phase_r == PH_CMD8 || phase_r == PH_CMD55 ||
     phase_r == PH_ACMD41 || phase_r == PH_CMD16) |-> pos_r <= POS_POLL)
    else $error("command byte position out of range");

endmodule

`default_nettype wire

@@ bench/sd_spi_card_init_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_card_init_sequencer_core_tb: self-checking bench for the SD SPI init
// sequencer. Scripted card sessions (dummy clocks, CMD0/CMD8, ACMD41 retry
// loop, CMD16) plus timeouts, bad answers, restarts and stray requests are
// streamed in under random idling on both sides. Every response word is
// predicted by a cycle-free model of the sequencer and checked per field.
// ----------------------------------------------------------------------------

module sd_spi_card_init_sequencer_core_tb;
  import sdinit_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned ITEMS_TARGET = 1550;
  localparam logic [1:0]  OP_RSVD      = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
  } req_t;

  typedef enum logic {REPLY, SILENT} reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'd0;
  logic [1:0]       in_tuser = 2'd0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_addr = 2'd0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  req_t        req_q[$];
  res_t        spi_step_q[$];
  logic        accepted = 1'b0;
  bit          idle_on = 1'b1;
  int unsigned req_total = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // sequencer model state and register copies
  phase_t         ph = PH_IDLE;
  logic [7:0]     bpos = 8'd0;
  logic [7:0]     polls = 8'd0;
  logic [9:0]     tries = 10'd0;
  logic [7:0]     poll_lim = POLL_LIMIT_RST;
  logic [9:0]     retry_lim = RETRY_LIMIT_RST;
  logic [7:0]     dummy_cnt = DUMMY_COUNT_RST;

  sd_spi_card_init_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t pack_step(input logic [7:0] tx, input logic valid,
                                     input logic sel, input logic desel,
                                     input logic delay, input logic fast,
                                     input logic [1:0] oc);
    res_t r;
    r.tx_byte        = tx;
    r.tx_valid       = valid;
    r.select_level   = sel;
    r.deselect_first = desel;
    r.delay_request  = delay;
    r.fast_clock     = fast;
    r.outcome        = oc;
    return r;
  endfunction

  function automatic logic [7:0] cmd_byte(input phase_t p, input logic [7:0] pos);
    logic [47:0] frame;
    case (p)
      PH_CMD0:   frame = {CMD_START | 8'd0,  32'd0,      CRC_CMD0};
      PH_CMD8:   frame = {CMD_START | 8'd8,  ARG_CMD8,   CRC_CMD8};
      PH_CMD55:  frame = {CMD_START | 8'd55, 32'd0,      CRC_NONE};
      PH_ACMD41: frame = {CMD_START | 8'd41, ARG_ACMD41, CRC_NONE};
      default:   frame = {CMD_START | 8'd16, ARG_CMD16,  CRC_NONE};
    endcase
    frame = frame >> (8 * (5 - int'(pos)));
    return frame[7:0];
  endfunction

  function automatic res_t card_status(input logic desel);
    logic [1:0] oc;
    oc = (ph == PH_DONE) ? OC_READY : ((ph == PH_FAIL) ? OC_FAIL : OC_RUN);
    return pack_step(8'd0, 1'b0, 1'b1, desel, 1'b0, ph == PH_DONE, oc);
  endfunction

  function automatic res_t begin_cmd(input phase_t p, input logic desel);
    ph    = p;
    bpos  = 8'd0;
    polls = 8'd0;
    return pack_step(cmd_byte(p, 8'd0), 1'b1, 1'b0, desel, 1'b0, 1'b0, OC_RUN);
  endfunction

  function automatic res_t close_cmd(input logic got, input logic [7:0] rx);
    case (ph)
      PH_CMD0: begin
        if (got && rx == RESP_IDLE) return begin_cmd(PH_CMD8, 1'b1);
        ph = PH_FAIL;
        return card_status(1'b1);
      end
      PH_CMD8: begin
        if (got) return begin_cmd(PH_CMD55, 1'b1);
        ph = PH_FAIL;
        return card_status(1'b1);
      end
      PH_CMD55: return begin_cmd(PH_ACMD41, 1'b1);
      PH_ACMD41: begin
        if (got && rx == RESP_OK) return begin_cmd(PH_CMD16, 1'b1);
        if (tries != 10'd1023) tries = tries + 10'd1;
        if (tries >= retry_lim) begin
          ph = PH_FAIL;
          return card_status(1'b1);
        end
        ph = PH_WAIT;
        return pack_step(8'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, OC_RUN);
      end
      default: begin
        ph = PH_DONE;
        return card_status(1'b1);
      end
    endcase
  endfunction

  function automatic res_t next_spi_step(input logic [1:0] op, input logic [7:0] rx);
    if (op == OP_START) begin
      ph    = PH_DUMMY;
      bpos  = 8'd0;
      polls = 8'd0;
      tries = 10'd0;
      return pack_step(BYTE_IDLE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, OC_RUN);
    end
    if (op == OP_DELAY && ph == PH_WAIT) return begin_cmd(PH_CMD55, 1'b0);
    if (op != OP_XFER || ph == PH_IDLE || ph == PH_WAIT || ph == PH_DONE || ph == PH_FAIL)
      return card_status(1'b0);
    if (ph == PH_DUMMY) begin
      if (int'(bpos) + 1 >= int'(dummy_cnt)) return begin_cmd(PH_CMD0, 1'b0);
      bpos = bpos + 8'd1;
      return pack_step(BYTE_IDLE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, OC_RUN);
    end
    if (bpos < POS_CRC) begin
      bpos = bpos + 8'd1;
      return pack_step(cmd_byte(ph, bpos), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, OC_RUN);
    end
    if (bpos == POS_CRC) begin
      bpos  = POS_POLL;
      polls = 8'd0;
      return pack_step(BYTE_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, OC_RUN);
    end
    if (rx != BYTE_IDLE) return close_cmd(1'b1, rx);
    if (polls != 8'hFF) polls = polls + 8'd1;
    if (polls >= poll_lim) return close_cmd(1'b0, rx);
    return pack_step(BYTE_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, OC_RUN);
  endfunction

  function automatic int unsigned poll_eff();
    return (poll_lim == 8'd0) ? 1 : int'(poll_lim);
  endfunction

  function automatic int unsigned retry_eff();
    return (retry_lim == 10'd0) ? 1 : int'(retry_lim);
  endfunction

  function automatic int unsigned dummy_eff();
    return (dummy_cnt == 8'd0) ? 1 : int'(dummy_cnt);
  endfunction

  function automatic logic [7:0] any_reply();
    return 8'($urandom_range(254));
  endfunction

  function automatic reply_t pick_how();
    if (poll_eff() <= 16) return ($urandom_range(5) == 0) ? SILENT : REPLY;
    return ($urandom_range(39) == 0) ? SILENT : REPLY;
  endfunction

  task automatic push_req(input logic [1:0] op, input logic [7:0] rx);
    req_t r;
    if ($urandom_range(99) < 3) begin
      r.op = OP_RSVD;
      r.rx = 8'($urandom_range(255));
      req_q.push_back(r);
    end
    r.op = op;
    r.rx = rx;
    req_q.push_back(r);
    req_total++;
  endtask

  task automatic push_stray();
    req_t r;
    case ($urandom_range(2))
      0:       r.op = OP_XFER;
      1:       r.op = OP_DELAY;
      default: r.op = OP_RSVD;
    endcase
    r.rx = 8'($urandom_range(255));
    req_q.push_back(r);
  endtask

  task automatic run_cmd(input reply_t how, input logic [7:0] answer);
    int unsigned waits;
    int unsigned cap;
    repeat (6) push_req(OP_XFER, 8'($urandom_range(255)));
    if (how == SILENT) begin
      waits = poll_eff();
    end else begin
      cap   = ($urandom_range(19) == 0) ? poll_eff() - 1 : poll_eff() - 1 < 6 ? poll_eff() - 1 : 6;
      waits = $urandom_range(cap);
    end
    repeat (waits) push_req(OP_XFER, BYTE_IDLE);
    if (how == REPLY) push_req(OP_XFER, answer);
  endtask

  task automatic run_session();
    bit          give_up;
    int unsigned n;
    int unsigned cap;
    push_req(OP_START, 8'($urandom_range(255)));
    repeat (dummy_eff()) push_req(OP_XFER, 8'($urandom_range(255)));
    case ($urandom_range(19))
      0: begin
        run_cmd(SILENT, 8'd0);
        repeat ($urandom_range(3)) push_stray();
        return;
      end
      1: begin
        run_cmd(REPLY, ($urandom_range(1) == 0) ? RESP_OK : 8'($urandom_range(2, 254)));
        repeat ($urandom_range(3)) push_stray();
        return;
      end
      2: begin
        // abandon mid-command; the next start restarts the card
        repeat ($urandom_range(1, 8)) push_req(OP_XFER, 8'($urandom_range(255)));
        return;
      end
      default: ;
    endcase
    run_cmd(REPLY, RESP_IDLE);
    if ($urandom_range(15) == 0) begin
      run_cmd(SILENT, 8'd0);
      repeat ($urandom_range(3)) push_stray();
      return;
    end
    run_cmd(REPLY, any_reply());
    give_up = retry_eff() <= 8 && $urandom_range(3) == 0;
    cap     = (retry_eff() - 1 < 4) ? retry_eff() - 1 : 4;
    n       = give_up ? retry_eff() : $urandom_range(cap);
    for (int i = 0; i < n; i++) begin
      run_cmd(pick_how(), any_reply());
      run_cmd(pick_how(), 8'($urandom_range(1, 254)));
      if (i + 1 < retry_eff()) begin
        if ($urandom_range(3) == 0) push_stray();
        push_req(OP_DELAY, 8'($urandom_range(255)));
      end
    end
    if (!give_up) begin
      run_cmd(pick_how(), any_reply());
      run_cmd(REPLY, RESP_OK);
      run_cmd(pick_how(), any_reply());
    end
    repeat ($urandom_range(3)) push_stray();
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned stop;
    stop = req_total + budget;
    while (req_total < stop) begin
      if ($urandom_range(11) == 0) begin
        repeat ($urandom_range(4, 16))
          push_req(2'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        run_session();
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk); while (req_q.size() != 0 || spi_step_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    case (idx)
      CFG_POLL_LIMIT:  poll_lim  = val[7:0];
      CFG_RETRY_LIMIT: retry_lim = val[9:0];
      default:         dummy_cnt = val[7:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= !(idle_on && $urandom_range(99) < 16);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || accepted) begin
      if (req_q.size() != 0 && !(idle_on && $urandom_range(99) < 16)) begin
        in_tvalid <= 1'b1;
        in_tuser  <= req_q[0].op;
        in_tdata  <= req_q[0].rx;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_bus
    res_t seen;
    res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = res_t'(out_tdata[14:0]);
        if (spi_step_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = spi_step_q.pop_front();
          if (seen.tx_byte !== want.tx_byte || seen.tx_valid !== want.tx_valid ||
              seen.select_level !== want.select_level ||
              seen.deselect_first !== want.deselect_first ||
              seen.delay_request !== want.delay_request ||
              seen.fast_clock !== want.fast_clock || seen.outcome !== want.outcome ||
              out_tdata[15] !== 1'b0) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch (exp/got): tx_byte %h/%h valid %b/%b sel %b/%b desel %b/%b",
                       want.tx_byte, seen.tx_byte, want.tx_valid, seen.tx_valid,
                       want.select_level, seen.select_level,
                       want.deselect_first, seen.deselect_first);
              $display("  delay %b/%b fast %b/%b outcome %0d/%0d pad -/%b",
                       want.delay_request, seen.delay_request,
                       want.fast_clock, seen.fast_clock,
                       want.outcome, seen.outcome, out_tdata[15]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        spi_step_q.push_back(next_spi_step(in_tuser, in_tdata));
        void'(req_q.pop_front());
      end
    end
    accepted <= rst_n && in_tvalid && in_tready;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stray requests while idle, restart during dummy clocks, CMD0 answered
    push_req(OP_XFER, 8'h00);
    push_req(OP_DELAY, 8'hFF);
    push_req(OP_RSVD, 8'hFF);
    push_req(OP_START, 8'h00);
    push_req(OP_XFER, 8'hFF);
    push_req(OP_START, 8'h5A);
    repeat (10) push_req(OP_XFER, 8'h00);
    repeat (6) push_req(OP_XFER, 8'hFF);
    push_req(OP_XFER, BYTE_IDLE);
    push_req(OP_XFER, RESP_IDLE);
    run_phase(250);
    settle();

    write_reg(CFG_POLL_LIMIT, 0);
    write_reg(CFG_RETRY_LIMIT, 0);
    write_reg(CFG_DUMMY_COUNT, 0);
    run_phase(120);
    settle();

    write_reg(CFG_POLL_LIMIT, 1);
    write_reg(CFG_RETRY_LIMIT, 1);
    write_reg(CFG_DUMMY_COUNT, 1);
    idle_on = 1'b0;
    run_phase(150);
    settle();
    idle_on = 1'b1;

    write_reg(CFG_POLL_LIMIT, 255);
    write_reg(CFG_RETRY_LIMIT, 1023);
    write_reg(CFG_DUMMY_COUNT, 255);
    run_phase(300);

    while (req_total < ITEMS_TARGET) begin
      settle();
      if ($urandom_range(2) != 0) write_reg(CFG_POLL_LIMIT, $urandom_range(1, 12));
      if ($urandom_range(2) != 0) write_reg(CFG_RETRY_LIMIT, $urandom_range(1, 8));
      if ($urandom_range(2) != 0) write_reg(CFG_DUMMY_COUNT, $urandom_range(1, 12));
      run_phase(150);
    end

    do @(negedge clk); while (req_q.size() != 0 || spi_step_q.size() != 0);
    repeat (20) @(negedge clk);
    if (errors == 0 && spi_step_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
